// ===== sv/qdc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the quadrature detent counter: field widths, detent patterns,
// action codes and configuration register indexes. No dependencies.
package qdc_pkg;

    localparam int ValueW = 16;
    localparam int StepW  = 2;
    localparam int PinsW  = 2;
    localparam int HistW  = 6;
    localparam int CfgIdxW = 3;
    localparam int InDataW  = 24;
    localparam int OutDataW = 24;

    localparam logic [HistW-1:0] CW_RISE  = 6'b000111;
    localparam logic [HistW-1:0] CW_FALL  = 6'b111000;
    localparam logic [HistW-1:0] CCW_RISE = 6'b001011;
    localparam logic [HistW-1:0] CCW_FALL = 6'b110100;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MIN_VALUE        = 3'd0,
        CFG_MAX_VALUE        = 3'd1,
        CFG_COUNT_ON_RISING  = 3'd2,
        CFG_COUNT_ON_FALLING = 3'd3,
        CFG_WRAP_AT_LIMITS   = 3'd4,
        CFG_CLEAR_ON_PRESS   = 3'd5
    } cfg_index_t;

    localparam logic signed [StepW-1:0] STEP_NONE = 2'sb00;
    localparam logic signed [StepW-1:0] STEP_CW   = 2'sb01;
    localparam logic signed [StepW-1:0] STEP_CCW  = 2'sb11;

    typedef struct packed {
        logic signed [StepW-1:0]  last_step;
        logic signed [ValueW-1:0] value;
    } result_t;

endpackage

// ===== sv/quadrature_detent_counter.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the skid entry is empty; a
// two-entry output stage lets the input keep accepting while one result
// waits on a stalled output.
// Reset (aresetn, synchronous, active low) clears the decoder state and the
// output stage and restores the configuration registers to their defaults.
// Depends on qdc_pkg.
module quadrature_detent_counter
    import qdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: pin_a, pin_b, pressed, new_value[15:0], zero padding.
    input  logic [InDataW-1:0]   s_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: value[15:0], last_step[1:0], changed, zero padding.
    output logic [OutDataW-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [ValueW-1:0]    cfg_data
);

    logic signed [ValueW-1:0] min_value_reg;
    logic signed [ValueW-1:0] max_value_reg;
    logic                     count_on_rising_reg;
    logic                     count_on_falling_reg;
    logic                     wrap_at_limits_reg;
    logic                     clear_on_press_reg;

    logic [PinsW-1:0]         previous_pins_reg, previous_pins_next;
    logic [HistW-1:0]         pin_history_reg, pin_history_next;
    logic signed [ValueW-1:0] count_value_reg, count_value_next;
    logic signed [StepW-1:0]  held_step_reg, held_step_next;

    result_t out_reg, skid_reg, result;
    logic    out_valid_reg, skid_valid_reg;

    action_t                  action;
    logic [PinsW-1:0]         pins;
    logic                     pressed;
    logic signed [ValueW-1:0] new_value;
    logic                     in_accept;
    logic [HistW-1:0]         hist_shift;
    logic                     match_cw, match_ccw;
    logic signed [ValueW-1:0] base_value;
    logic signed [ValueW:0]   inc_value, dec_value;

    assign action    = action_t'(s_tuser);
    assign pins      = s_tdata[1:0];
    assign pressed   = s_tdata[2];
    assign new_value = s_tdata[ValueW+2:3];
    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;

    assign hist_shift = {pin_history_reg[HistW-PinsW-1:0], pins};
    assign match_cw   = (count_on_rising_reg && hist_shift == CW_RISE) ||
                        (count_on_falling_reg && hist_shift == CW_FALL);
    assign match_ccw  = (count_on_rising_reg && hist_shift == CCW_RISE) ||
                        (count_on_falling_reg && hist_shift == CCW_FALL);
    assign base_value = (clear_on_press_reg && pressed) ? '0 : count_value_reg;
    assign inc_value  = {base_value[ValueW-1], base_value} + 17'sd1;
    assign dec_value  = {base_value[ValueW-1], base_value} - 17'sd1;

    always_comb begin
        previous_pins_next = previous_pins_reg;
        pin_history_next   = pin_history_reg;
        count_value_next   = count_value_reg;
        held_step_next     = held_step_reg;
        case (action)
            ACT_SAMPLE: begin
                count_value_next = base_value;
                if (pins != previous_pins_reg) begin
                    previous_pins_next = pins;
                    pin_history_next   = hist_shift;
                    held_step_next     = STEP_NONE;
                    if (match_cw) begin
                        held_step_next = STEP_CW;
                        if (inc_value > $signed({max_value_reg[ValueW-1], max_value_reg})) begin
                            count_value_next = wrap_at_limits_reg ? min_value_reg
                                                                  : max_value_reg;
                        end else begin
                            count_value_next = inc_value[ValueW-1:0];
                        end
                    end else if (match_ccw) begin
                        held_step_next = STEP_CCW;
                        if (dec_value < $signed({min_value_reg[ValueW-1], min_value_reg})) begin
                            count_value_next = wrap_at_limits_reg ? max_value_reg
                                                                  : min_value_reg;
                        end else begin
                            count_value_next = dec_value[ValueW-1:0];
                        end
                    end
                end
            end
            ACT_LOAD:  count_value_next = new_value;
            ACT_CLEAR: count_value_next = '0;
            default:   count_value_next = count_value_reg;
        endcase
        result.value     = count_value_next;
        result.last_step = held_step_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg        <= '0;
            max_value_reg        <= 16'sd127;
            count_on_rising_reg  <= 1'b0;
            count_on_falling_reg <= 1'b1;
            wrap_at_limits_reg   <= 1'b1;
            clear_on_press_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_VALUE:        min_value_reg        <= cfg_data;
                CFG_MAX_VALUE:        max_value_reg        <= cfg_data;
                CFG_COUNT_ON_RISING:  count_on_rising_reg  <= cfg_data[0];
                CFG_COUNT_ON_FALLING: count_on_falling_reg <= cfg_data[0];
                CFG_WRAP_AT_LIMITS:   wrap_at_limits_reg   <= cfg_data[0];
                CFG_CLEAR_ON_PRESS:   clear_on_press_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_pins_reg <= '0;
            pin_history_reg   <= '0;
            count_value_reg   <= '0;
            held_step_reg     <= STEP_NONE;
        end else if (in_accept) begin
            previous_pins_reg <= previous_pins_next;
            pin_history_reg   <= pin_history_next;
            count_value_reg   <= count_value_next;
            held_step_reg     <= held_step_next;
        end
    end

    // The skid entry only fills when the output entry is held by a stalled sink.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (in_accept) begin
                out_reg <= result;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg) begin
            if (in_accept) begin
                out_reg       <= result;
                out_valid_reg <= 1'b1;
            end
        end else if (in_accept) begin
            skid_reg       <= result;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, (out_reg.last_step != STEP_NONE), out_reg.last_step,
                       out_reg.value};

endmodule

// ===== sv/qdc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the quadrature detent counter, bound to its top level.
// Depends on qdc_pkg and quadrature_detent_counter.
module qdc_checker
    import qdc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [InDataW-1:0]  s_tdata,
    input logic [1:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_changed_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18] == (m_tdata[17:16] != 2'b00))
        else $error("Changed flag disagrees with last step.");

    a_step_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[17:16] != 2'b10)
        else $error("Illegal last step code.");

    a_load_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == ACT_LOAD && !m_tvalid)
        |=> m_tvalid && m_tdata[15:0] == $past(s_tdata[18:3]))
        else $error("Loaded value not reported in the next transaction.");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("Output transaction changed while stalled.");

endmodule

bind quadrature_detent_counter qdc_checker u_qdc_checker (.*);

// ===== tb/sv/tb_quadrature_detent_counter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for quadrature_detent_counter: a directed table, then
// random encoder walks under several register settings and idling phases.
// Depends on qdc_pkg and the quadrature_detent_counter RTL.
module tb_quadrature_detent_counter;
    import qdc_pkg::*;

    localparam int PhaseCount     = 8;
    localparam int ItemsPerPhase  = 232;
    localparam int WatchdogLimit  = 4000;
    localparam int MaxPrinted     = 40;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic signed [ValueW-1:0] value;
        logic signed [StepW-1:0]  step;
        logic                     changed;
    } reading_t;

    typedef struct {
        action_t                  act;
        logic                     pin_a;
        logic                     pin_b;
        logic                     pressed;
        logic signed [ValueW-1:0] new_value;
        bit                       typed;
        logic signed [ValueW-1:0] want_value;
        logic signed [StepW-1:0]  want_step;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutDataW-1:0]  m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [ValueW-1:0]    cfg_data = '0;

    quadrature_detent_counter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the counter state and its registers.
    logic [PinsW-1:0]         prev_pins;
    logic [HistW-1:0]         pin_hist;
    logic signed [ValueW-1:0] count;
    logic signed [StepW-1:0]  held_step;
    logic signed [ValueW-1:0] limit_lo;
    logic signed [ValueW-1:0] limit_hi;
    bit                       on_rising;
    bit                       on_falling;
    bit                       wraps;
    bit                       clears_on_press;

    reading_t      pending_readings[$];
    reading_t      want_reading;
    directed_row_t directed_rows[$];
    idle_mode_t    idle_mode = IDLE_NONE;
    int            mismatches = 0;
    int            accepted = 0;
    int            detents = 0;
    int            settings_used = 0;
    int            quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MaxPrinted) begin
            $display("mismatch %0d at %0t: %s got %0d expected %0d",
                     mismatches, $realtime, what, got, want);
        end
    endtask

    // Advances the shadow state by one input transaction and returns the reading.
    task automatic advance_counter(input action_t act, input logic [PinsW-1:0] pins,
                                   input logic pressed,
                                   input logic signed [ValueW-1:0] new_value,
                                   output reading_t reading);
        int stepped;
        if (act == ACT_SAMPLE) begin
            if (clears_on_press && pressed) begin
                count = '0;
            end
            if (pins != prev_pins) begin
                pin_hist = {pin_hist[HistW-3:0], pins};
                held_step = STEP_NONE;
                if ((on_rising && pin_hist == CW_RISE) ||
                    (on_falling && pin_hist == CW_FALL)) begin
                    stepped = int'(count) + 1;
                    held_step = STEP_CW;
                    if (stepped > int'(limit_hi)) begin
                        stepped = wraps ? int'(limit_lo) : int'(limit_hi);
                    end
                    count = stepped[ValueW-1:0];
                    detents++;
                end else if ((on_rising && pin_hist == CCW_RISE) ||
                             (on_falling && pin_hist == CCW_FALL)) begin
                    stepped = int'(count) - 1;
                    held_step = STEP_CCW;
                    if (stepped < int'(limit_lo)) begin
                        stepped = wraps ? int'(limit_hi) : int'(limit_lo);
                    end
                    count = stepped[ValueW-1:0];
                    detents++;
                end
                prev_pins = pins;
            end
        end else if (act == ACT_LOAD) begin
            count = new_value;
        end else if (act == ACT_CLEAR) begin
            count = '0;
        end
        reading.value = count;
        reading.step = held_step;
        reading.changed = (held_step != STEP_NONE);
    endtask

    task automatic send_item(input action_t act, input logic pin_a, input logic pin_b,
                             input logic pressed, input logic signed [ValueW-1:0] new_value,
                             output reading_t predicted);
        int gap;
        gap = 0;
        if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
            while (gap < 40 &&
                   $urandom_range(99) < (idle_mode == IDLE_SENDER ? 66 : 24)) begin
                gap++;
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, new_value, pressed, pin_b, pin_a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accepted++;
        advance_counter(act, {pin_b, pin_a}, pressed, new_value, predicted);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [ValueW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_MIN_VALUE:        limit_lo = data;
            CFG_MAX_VALUE:        limit_hi = data;
            CFG_COUNT_ON_RISING:  on_rising = data[0];
            CFG_COUNT_ON_FALLING: on_falling = data[0];
            CFG_WRAP_AT_LIMITS:   wraps = data[0];
            CFG_CLEAR_ON_PRESS:   clears_on_press = data[0];
            default: ;
        endcase
    endtask

    task automatic add_row(input action_t act, input logic pin_a, input logic pin_b,
                           input logic pressed, input logic signed [ValueW-1:0] new_value,
                           input bit typed, input logic signed [ValueW-1:0] want_value,
                           input logic signed [StepW-1:0] want_step);
        directed_row_t row;
        row.act = act;
        row.pin_a = pin_a;
        row.pin_b = pin_b;
        row.pressed = pressed;
        row.new_value = new_value;
        row.typed = typed;
        row.want_value = want_value;
        row.want_step = want_step;
        directed_rows.push_back(row);
    endtask

    always @(posedge aclk) begin
        if (idle_mode == IDLE_RECEIVER) begin
            m_tready <= ($urandom_range(99) >= 66);
        end else if (idle_mode == IDLE_BOTH) begin
            m_tready <= ($urandom_range(99) >= 24);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("result with nothing pending, value",
                                int'($signed(m_tdata[15:0])), 0);
            end else begin
                want_reading = pending_readings.pop_front();
                if (m_tdata[15:0] !== want_reading.value) begin
                    report_mismatch("value", int'($signed(m_tdata[15:0])),
                                    int'(want_reading.value));
                end
                if (m_tdata[17:16] !== want_reading.step) begin
                    report_mismatch("last_step", int'($signed(m_tdata[17:16])),
                                    int'(want_reading.step));
                end
                if (m_tdata[18] !== want_reading.changed) begin
                    report_mismatch("changed", int'(m_tdata[18]),
                                    int'(want_reading.changed));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("timeout: no transaction for %0d cycles", WatchdogLimit);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        reading_t                 predicted;
        directed_row_t            row;
        logic signed [ValueW-1:0] lo;
        logic signed [ValueW-1:0] hi;
        bit                       rise;
        bit                       fall;
        bit                       wrap;
        bit                       clr;
        action_t                  act;
        logic [PinsW-1:0]         walk_pins;
        bit                       walk_cw;
        logic [PinsW-1:0]         pins;
        logic                     pressed;
        logic signed [ValueW-1:0] new_value;
        int                       pick;

        prev_pins = '0;
        pin_hist = '0;
        count = '0;
        held_step = STEP_NONE;
        limit_lo = 16'sd0;
        limit_hi = 16'sd127;
        on_rising = 1'b0;
        on_falling = 1'b1;
        wraps = 1'b1;
        clears_on_press = 1'b0;
        walk_pins = '0;
        walk_cw = 1'b1;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults after reset: range 0..127, falling detents only, wrapping.
        add_row(ACT_NONE,   1, 1, 1, 16'sh1234, 1, 16'sd0,  STEP_NONE);
        add_row(ACT_LOAD,   1, 0, 1, 16'sd32767, 1, 16'sd32767, STEP_NONE);
        add_row(ACT_LOAD,   0, 1, 0, -16'sd32768, 1, -16'sd32768, STEP_NONE);
        add_row(ACT_CLEAR,  1, 1, 1, 16'sh7fff, 1, 16'sd0, STEP_NONE);
        add_row(ACT_SAMPLE, 1, 1, 1, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 1, 0, 16'shffff, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 0, 0, 16'sh5555, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 0, 1, 16'shaaaa, 0, 0, STEP_NONE);
        add_row(ACT_LOAD,   0, 0, 0, 16'sd127, 1, 16'sd127, STEP_CW);
        add_row(ACT_SAMPLE, 1, 1, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 1, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 0, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 1, 1, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 1, 0, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 0, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 1, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_LOAD,   1, 1, 1, -16'sd32768, 1, -16'sd32768, STEP_NONE);
        add_row(ACT_SAMPLE, 1, 1, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 1, 0, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 0, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_LOAD,   0, 0, 0, 16'sd32767, 1, 16'sd32767, STEP_CCW);
        add_row(ACT_SAMPLE, 1, 1, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 1, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_SAMPLE, 0, 0, 0, 16'sh0000, 0, 0, STEP_NONE);
        add_row(ACT_CLEAR,  0, 1, 1, 16'sh8000, 1, 16'sd0, STEP_CW);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.act, row.pin_a, row.pin_b, row.pressed, row.new_value, predicted);
            if (row.typed) begin
                predicted.value = row.want_value;
                predicted.step = row.want_step;
                predicted.changed = (row.want_step != STEP_NONE);
            end
            pending_readings.push_back(predicted);
        end
        drain_results();

        for (int p = 0; p < PhaseCount; p++) begin
            case (p)
                0: begin lo = 16'sd0; hi = 16'sd127; rise = 0; fall = 1; wrap = 1; clr = 0; end
                1: begin lo = -16'sd32768; hi = 16'sd32767; rise = 1; fall = 1; wrap = 1; clr = 1; end
                2: begin lo = -16'sd5; hi = 16'sd5; rise = 1; fall = 0; wrap = 0; clr = 1; end
                3: begin lo = 16'sd10; hi = -16'sd10; rise = 0; fall = 1; wrap = 1; clr = 0; end
                4: begin lo = 16'sd32767; hi = -16'sd32768; rise = 1; fall = 1; wrap = 0; clr = 1; end
                5: begin lo = 16'sd0; hi = 16'sd0; rise = 1; fall = 1; wrap = 1; clr = 0; end
                6: begin
                    lo = 16'($urandom);
                    hi = 16'($urandom);
                    rise = 1'($urandom_range(1));
                    fall = 1'($urandom_range(1));
                    wrap = 1'($urandom_range(1));
                    clr = 1'($urandom_range(1));
                end
                default: begin
                    lo = -16'sd32768; hi = 16'sd32767; rise = 1; fall = 1; wrap = 0; clr = 0;
                end
            endcase
            write_register(CFG_MIN_VALUE, lo);
            write_register(CFG_MAX_VALUE, hi);
            write_register(CFG_COUNT_ON_RISING, {15'b0, rise});
            write_register(CFG_COUNT_ON_FALLING, {15'b0, fall});
            write_register(CFG_WRAP_AT_LIMITS, {15'b0, wrap});
            write_register(CFG_CLEAR_ON_PRESS, {15'b0, clr});
            cfg_wr_en <= 1'b0;
            settings_used++;
            idle_mode = idle_mode_t'(p % 4);

            for (int n = 0; n < ItemsPerPhase; n++) begin
                pick = $urandom_range(99);
                new_value = 16'($urandom);
                pins = 2'($urandom_range(3));
                pressed = ($urandom_range(9) == 0);
                if (pick < 8) begin
                    act = ACT_LOAD;
                    case ($urandom_range(2))
                        0: new_value = 16'(limit_lo + ($urandom_range(4) - 2));
                        1: new_value = 16'(limit_hi + ($urandom_range(4) - 2));
                        default: ;
                    endcase
                end else if (pick < 12) begin
                    act = ACT_CLEAR;
                end else if (pick < 15) begin
                    act = ACT_NONE;
                end else begin
                    act = ACT_SAMPLE;
                    pick = $urandom_range(99);
                    if (pick < 70) begin
                        if ($urandom_range(99) < 8) begin
                            walk_cw = !walk_cw;
                        end
                        case (walk_pins)
                            2'b00: walk_pins = walk_cw ? 2'b01 : 2'b10;
                            2'b01: walk_pins = walk_cw ? 2'b11 : 2'b00;
                            2'b11: walk_pins = walk_cw ? 2'b10 : 2'b01;
                            default: walk_pins = walk_cw ? 2'b00 : 2'b11;
                        endcase
                        pins = walk_pins;
                    end else if (pick < 85) begin
                        pins = walk_pins;
                    end else begin
                        walk_pins = pins;
                    end
                end
                send_item(act, pins[0], pins[1], pressed, new_value, predicted);
                pending_readings.push_back(predicted);
                if (p == 2 && n == ItemsPerPhase / 2) begin
                    drain_results();
                end
            end
            drain_results();
        end

        idle_mode = IDLE_NONE;
        drain_results();

        $display("Ran %0d transactions across %0d register settings and four idling phases,",
                 accepted, settings_used);
        $display("with %0d detents counted and %0d mismatches.", detents, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== quadrature_detent_counter.f =====
sv/qdc_pkg.sv
sv/quadrature_detent_counter.sv
sv/qdc_checker.sv
tb/sv/tb_quadrature_detent_counter.sv
